FILE: rtl/hss_pkg.sv
// heater safety supervisor package: item, result and register types,
// fault codes, register indexes and reset values
// no dependencies
`timescale 1ns / 1ps

package hss_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UPDATE_INTERVAL = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE        = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DOUBLE_CLICK    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OVERHEAT_LIMIT  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_STEP        = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HEATING_TIMEOUT = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_SETPOINT    = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ELEMENT_FAULT   = 3'd7;

   localparam logic [15:0]        RST_UPDATE_INTERVAL = 16'd200;
   localparam logic [15:0]        RST_DEBOUNCE        = 16'd50;
   localparam logic [15:0]        RST_DOUBLE_CLICK    = 16'd300;
   localparam logic signed [14:0] RST_OVERHEAT_LIMIT  = 15'sd2560;
   localparam logic [13:0]        RST_MAX_STEP        = 14'd80;
   localparam logic [31:0]        RST_HEATING_TIMEOUT = 32'd60000;
   localparam logic [9:0]         RST_MAX_SETPOINT    = 10'd150;
   localparam logic [15:0]        RST_ELEMENT_FAULT   = 16'd5000;

   // element check margin, 5 degrees in 1/16 degree
   localparam logic signed [16:0] ELEMENT_MARGIN = 17'sd80;

   localparam logic [15:0] RTD_ALL_ONES = 16'hFFFF;
   localparam logic [15:0] RTD_ZERO     = 16'h0000;

   typedef enum logic [2:0] {
      ERR_NONE         = 3'd0,
      ERR_DISCONNECTED = 3'd1,
      ERR_OVERHEAT     = 3'd2,
      ERR_STEP         = 3'd3,
      ERR_ELEMENT      = 3'd4,
      ERR_TIMEOUT      = 3'd5
   } err_type;

   typedef struct packed {
      logic [15:0]        update_interval_ms;
      logic [15:0]        debounce_ms;
      logic [15:0]        double_click_ms;
      logic signed [14:0] overheat_limit;
      logic [13:0]        max_step;
      logic [31:0]        heating_timeout_ms;
      logic [9:0]         max_setpoint;
      logic [15:0]        element_fault_ms;
   } cfg_type;

   typedef struct packed {
      logic [31:0]        now_ms;
      logic               button_level;
      logic [8:0]         encoder_count;
      logic [15:0]        rtd_code;
      logic signed [14:0] sample_temperature;
   } req_type;

   typedef struct packed {
      logic        heating_on;
      logic        drive_allowed;
      err_type     error_code;
      logic        update_done;
      logic [9:0]  setpoint_deg;
   } rsp_type;

endpackage

FILE: rtl/hss_csr.sv
// heater safety supervisor configuration registers
// depends on hss_pkg
`timescale 1ns / 1ps

module hss_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [hss_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [hss_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   output hss_pkg::cfg_type                     cfg
);
   import hss_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_UPDATE_INTERVAL: cfg_in.update_interval_ms = csr_wdata[15:0];
            CSR_DEBOUNCE:        cfg_in.debounce_ms        = csr_wdata[15:0];
            CSR_DOUBLE_CLICK:    cfg_in.double_click_ms    = csr_wdata[15:0];
            CSR_OVERHEAT_LIMIT:  cfg_in.overheat_limit     = csr_wdata[14:0];
            CSR_MAX_STEP:        cfg_in.max_step           = csr_wdata[13:0];
            CSR_HEATING_TIMEOUT: cfg_in.heating_timeout_ms = csr_wdata[31:0];
            CSR_MAX_SETPOINT:    cfg_in.max_setpoint       = csr_wdata[9:0];
            CSR_ELEMENT_FAULT:   cfg_in.element_fault_ms   = csr_wdata[15:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.update_interval_ms <= RST_UPDATE_INTERVAL;
         cfg_ff.debounce_ms        <= RST_DEBOUNCE;
         cfg_ff.double_click_ms    <= RST_DOUBLE_CLICK;
         cfg_ff.overheat_limit     <= RST_OVERHEAT_LIMIT;
         cfg_ff.max_step           <= RST_MAX_STEP;
         cfg_ff.heating_timeout_ms <= RST_HEATING_TIMEOUT;
         cfg_ff.max_setpoint       <= RST_MAX_SETPOINT;
         cfg_ff.element_fault_ms   <= RST_ELEMENT_FAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/hss_core.sv
// heater safety supervisor pass logic: button, heating session and
// sensor evaluation state, updated once per advanced pass
// depends on hss_pkg
`timescale 1ns / 1ps

module hss_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  hss_pkg::cfg_type  cfg,
   input  hss_pkg::req_type  item,
   output hss_pkg::rsp_type  result
);
   import hss_pkg::*;

   logic               prev_btn_ff,    prev_btn_in;
   logic [31:0]        press_time_ff,  press_time_in;
   logic               awaiting_ff,    awaiting_in;
   logic               heating_ff,     heating_in;
   logic [31:0]        start_time_ff,  start_time_in;
   logic [31:0]        last_update_ff, last_update_in;
   logic signed [14:0] prev_temp_ff,   prev_temp_in;
   logic [31:0]        last_valid_ff,  last_valid_in;
   logic signed [14:0] ctrl_temp_ff,   ctrl_temp_in;
   err_type            fault_ff,       fault_in;

   logic               done;
   logic [31:0]        click_gap;
   logic [31:0]        window_age;
   logic [9:0]         setpoint;
   logic signed [15:0] temp_diff;
   logic [15:0]        temp_mag;
   logic signed [16:0] element_floor;
   logic signed [16:0] drive_limit;

   assign setpoint = ({1'b0, item.encoder_count} < cfg.max_setpoint) ?
                     {1'b0, item.encoder_count} : cfg.max_setpoint;

   assign temp_diff = 16'(item.sample_temperature) - 16'(prev_temp_ff);
   assign temp_mag  = temp_diff[15] ? 16'(-temp_diff) : 16'(temp_diff);
   assign element_floor = $signed({3'b000, setpoint, 4'b0000}) - ELEMENT_MARGIN;

   always_comb begin
      prev_btn_in    = prev_btn_ff;
      press_time_in  = press_time_ff;
      awaiting_in    = awaiting_ff;
      heating_in     = heating_ff;
      start_time_in  = start_time_ff;
      last_update_in = last_update_ff;
      prev_temp_in   = prev_temp_ff;
      last_valid_in  = last_valid_ff;
      ctrl_temp_in   = ctrl_temp_ff;
      fault_in       = fault_ff;
      done           = 1'b0;

      // debounced press, double click toggles
      click_gap = item.now_ms - press_time_ff;
      if (item.button_level != prev_btn_ff) begin
         if (!item.button_level && click_gap > {16'd0, cfg.debounce_ms}) begin
            if (awaiting_ff && click_gap <= {16'd0, cfg.double_click_ms}) begin
               heating_in  = !heating_ff;
               awaiting_in = 1'b0;
               if (!heating_ff) begin
                  start_time_in = item.now_ms;
               end
            end else begin
               awaiting_in   = 1'b1;
               press_time_in = item.now_ms;
            end
         end
         prev_btn_in = item.button_level;
      end

      // lone click whose window ran out
      window_age = item.now_ms - press_time_in;
      if (awaiting_in && window_age > {16'd0, cfg.double_click_ms}) begin
         awaiting_in   = 1'b0;
         heating_in    = 1'b1;
         start_time_in = item.now_ms;
      end

      // sensor evaluation
      if ((item.now_ms - last_update_ff) >= {16'd0, cfg.update_interval_ms}) begin
         done           = 1'b1;
         last_update_in = item.now_ms;
         fault_in       = ERR_NONE;
         if (item.rtd_code == RTD_ZERO || item.rtd_code == RTD_ALL_ONES) begin
            fault_in   = ERR_DISCONNECTED;
            heating_in = 1'b0;
         end else begin
            if (item.sample_temperature > cfg.overheat_limit) begin
               fault_in = ERR_OVERHEAT;
            end else if (temp_mag > {2'b00, cfg.max_step}) begin
               fault_in = ERR_STEP;
            end else if (heating_in &&
                         (item.now_ms - last_valid_ff) > {16'd0, cfg.element_fault_ms} &&
                         17'(ctrl_temp_ff) < element_floor) begin
               fault_in = ERR_ELEMENT;
            end else if (heating_in &&
                         (item.now_ms - start_time_in) > cfg.heating_timeout_ms) begin
               fault_in = ERR_TIMEOUT;
            end
            if (fault_in != ERR_NONE) begin
               heating_in = 1'b0;
            end
            if (heating_in && fault_in == ERR_NONE) begin
               ctrl_temp_in = item.sample_temperature;
            end
            prev_temp_in  = item.sample_temperature;
            last_valid_in = item.now_ms;
         end
      end
   end

   assign drive_limit = $signed({3'b000, cfg.max_setpoint, 4'b0000});

   always_comb begin
      result.heating_on    = heating_in;
      result.drive_allowed = heating_in && (17'(prev_temp_in) < drive_limit);
      result.error_code    = fault_in;
      result.update_done   = done;
      result.setpoint_deg  = setpoint;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_btn_ff    <= 1'b1;
         press_time_ff  <= '0;
         awaiting_ff    <= 1'b0;
         heating_ff     <= 1'b0;
         start_time_ff  <= '0;
         last_update_ff <= '0;
         prev_temp_ff   <= '0;
         last_valid_ff  <= '0;
         ctrl_temp_ff   <= '0;
         fault_ff       <= ERR_NONE;
      end else if (advance) begin
         prev_btn_ff    <= prev_btn_in;
         press_time_ff  <= press_time_in;
         awaiting_ff    <= awaiting_in;
         heating_ff     <= heating_in;
         start_time_ff  <= start_time_in;
         last_update_ff <= last_update_in;
         prev_temp_ff   <= prev_temp_in;
         last_valid_ff  <= last_valid_in;
         ctrl_temp_ff   <= ctrl_temp_in;
         fault_ff       <= fault_in;
      end
   end

endmodule

FILE: rtl/heater_safety_supervisor.sv
// heater safety supervisor top level: input register, pass logic, result register
// depends on hss_pkg, hss_csr, hss_core
`timescale 1ns / 1ps

// One control pass per transfer, one pass per clock sustained while the rsp side
// takes results. A pass sits in the input register, is evaluated combinationally
// by the pass logic against the supervisor state, and lands in the result
// register, which raises rsp_valid. The result register lets a new pass move in
// while a finished result waits, and only a stalled rsp side with both
// registers full holds off req_ready. Configuration writes take effect on the
// next clock and are meant for idle periods.

module heater_safety_supervisor (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [hss_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [hss_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [31:0]                          req_now_ms,
   input  logic                                 req_button_level,
   input  logic [8:0]                           req_encoder_count,
   input  logic [15:0]                          req_rtd_code,
   input  logic signed [14:0]                   req_sample_temperature,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_heating_on,
   output logic                                 rsp_drive_allowed,
   output logic [2:0]                           rsp_error_code,
   output logic                                 rsp_update_done,
   output logic [9:0]                           rsp_setpoint_deg
);
   import hss_pkg::*;

   cfg_type cfg;
   req_type item_ff;
   rsp_type result;
   rsp_type rsp_ff;
   logic    in_valid_ff;
   logic    rsp_valid_ff;
   logic    advance;

   hss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.now_ms             <= req_now_ms;
         item_ff.button_level       <= req_button_level;
         item_ff.encoder_count      <= req_encoder_count;
         item_ff.rtd_code           <= req_rtd_code;
         item_ff.sample_temperature <= req_sample_temperature;
      end
   end

   hss_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cfg     (cfg),
      .item    (item_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_heating_on    = rsp_ff.heating_on;
   assign rsp_drive_allowed = rsp_ff.drive_allowed;
   assign rsp_error_code    = rsp_ff.error_code;
   assign rsp_update_done   = rsp_ff.update_done;
   assign rsp_setpoint_deg  = rsp_ff.setpoint_deg;

endmodule

FILE: rtl/hss_checker.sv
// heater safety supervisor port checker and its bind to the top level
// depends on hss_pkg, heater_safety_supervisor
`timescale 1ns / 1ps

module hss_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_heating_on,
   input logic       rsp_drive_allowed,
   input logic [2:0] rsp_error_code,
   input logic       rsp_update_done,
   input logic [9:0] rsp_setpoint_deg
);
   import hss_pkg::*;

   // stalled result holds its error code, heating flag and setpoint
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_error_code) &&
      $stable(rsp_heating_on) && $stable(rsp_setpoint_deg))
      else $error("stalled result changed");

   // drive only inside a heating session
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drive_allowed |-> rsp_heating_on)
      else $error("drive allowed without heating");

   // a fault found on an evaluation ends heating
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_update_done && rsp_error_code != ERR_NONE |-> !rsp_heating_on)
      else $error("heating on after fault");

   // no result straight out of reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind heater_safety_supervisor hss_checker u_hss_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_heating_on    (rsp_heating_on),
   .rsp_drive_allowed (rsp_drive_allowed),
   .rsp_error_code    (rsp_error_code),
   .rsp_update_done   (rsp_update_done),
   .rsp_setpoint_deg  (rsp_setpoint_deg)
);
